### rtl/core/longest_ones_run_with_k_flips_unit_assert.svh
// Assertion macros for the RTL of the longest-ones-run block; only the zero queue uses them.
`ifndef LONGEST_ONES_RUN_WITH_K_FLIPS_UNIT_ASSERT_SVH
`define LONGEST_ONES_RUN_WITH_K_FLIPS_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define LOKF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lokf: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define LOKF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lokf: next-cycle check failed");

`endif

### rtl/core/lokf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lokf_pkg;

  localparam int unsigned MAX_LEN_DEFAULT        = 65536;
  localparam int unsigned MAX_FLIP_DEPTH_DEFAULT = 256;

  localparam int unsigned MAX_FLIPS_W   = 8;
  localparam int unsigned BEST_LENGTH_W = 17;
  localparam int unsigned BEST_POS_W    = 16;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 56;

  // Zero-queue command for one accepted bit.
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } q_cmd_t;

endpackage

`default_nettype wire

### rtl/core/lokf_zero_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "longest_ones_run_with_k_flips_unit_assert.svh"

module lokf_zero_queue #(
  parameter int unsigned DEPTH = lokf_pkg::MAX_FLIP_DEPTH_DEFAULT,
  parameter int unsigned POS_W = 16,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned CNT_W = 9
) (
  input  wire                  clk,
  input  wire                  rst,
  input  lokf_pkg::q_cmd_t     cmd,
  input  wire [POS_W-1:0]      push_pos,
  output logic [CNT_W-1:0]     count,
  output logic [POS_W-1:0]     head_val
);

  localparam int unsigned SUM_W = CNT_W + 1;

  logic [POS_W-1:0] mem [DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] head_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cnt_keep;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] rd_addr;
  logic [POS_W-1:0] rd_q;
  logic [POS_W-1:0] byp_data;
  logic             byp_hit;
  logic [POS_W-1:0] second_val;
  logic [POS_W-1:0] head_val_next;

  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign cnt_keep = cmd.pop ? count - CNT_W'(1) : count;

  always_comb begin
    if (cmd.flush) begin
      head_next  = '0;
      count_next = '0;
    end else begin
      head_next  = cmd.pop ? head_inc : head;
      count_next = cmd.push ? cnt_keep + CNT_W'(1) : cnt_keep;
    end
  end

  // Ring slot for the new zero: wrap once past the end.
  always_comb begin
    tail_sum = SUM_W'(head_next) + SUM_W'(cnt_keep);
    if (tail_sum >= SUM_W'(DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(DEPTH);
    end
    tail = IDX_W'(tail_sum);
  end

  // Prefetch the entry behind the head so a pop never waits on the memory.
  assign rd_addr = (head_next == IDX_W'(DEPTH - 1)) ? '0 : head_next + IDX_W'(1);
  assign second_val = byp_hit ? byp_data : rd_q;

  always_comb begin
    head_val_next = head_val;
    if (cmd.push && (cnt_keep == '0)) begin
      head_val_next = push_pos;
    end else if (cmd.pop) begin
      head_val_next = second_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= push_pos;
    end
  end

  always_ff @(posedge clk) begin
    rd_q     <= mem[rd_addr];
    byp_hit  <= cmd.push && (tail == rd_addr);
    byp_data <= push_pos;
    head_val <= head_val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  `LOKF_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `LOKF_ASSERT_NOW(a_pop_needs_entry, clk, rst, cmd.pop, (count != '0) && cmd.push)
  `LOKF_ASSERT_NEXT(a_flush_empties, clk, rst, cmd.flush, count == '0)
  `LOKF_ASSERT_NOW(a_push_has_room, clk, rst, cmd.push && !cmd.flush,
                   cnt_keep < CNT_W'(DEPTH))

endmodule

`default_nettype wire

### rtl/core/lokf_window.sv
`timescale 1ns / 1ps
`default_nettype none

module lokf_window #(
  parameter int unsigned MAX_LEN = lokf_pkg::MAX_LEN_DEFAULT,
  parameter int unsigned DEPTH   = lokf_pkg::MAX_FLIP_DEPTH_DEFAULT,
  parameter int unsigned POS_W   = 16,
  parameter int unsigned POS_CW  = 17,
  parameter int unsigned CNT_W   = 9
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 accept,
  input  wire                                 bit_value,
  input  wire                                 last_bit,
  input  wire [lokf_pkg::MAX_FLIPS_W-1:0]     max_flips,
  input  wire [CNT_W-1:0]                     q_count,
  input  wire [POS_W-1:0]                     q_head_val,
  output lokf_pkg::q_cmd_t                    q_cmd,
  output logic [POS_W-1:0]                    q_push_pos,
  output logic [POS_CW-1:0]                   res_len,
  output logic [POS_CW-1:0]                   res_from,
  output logic [POS_W-1:0]                    res_to,
  output logic                                res_overflow
);

  localparam int unsigned CMP_W = (CNT_W > lokf_pkg::MAX_FLIPS_W) ? CNT_W
                                                                   : lokf_pkg::MAX_FLIPS_W;

  logic [POS_CW-1:0] position;
  logic [POS_CW-1:0] window_left;
  logic [POS_CW-1:0] best_len;
  logic [POS_CW-1:0] best_from;
  logic [POS_W-1:0]  best_to;
  logic              overflow_seen;

  logic              active;
  logic [POS_W-1:0]  p;
  logic [POS_CW-1:0] p_plus1;
  logic [CMP_W-1:0]  mf_ext;
  logic [CMP_W-1:0]  limit;
  logic              no_flips;
  logic              is_zero;
  logic              pop;
  logic [POS_CW-1:0] wl_step;
  logic [POS_CW-1:0] len;

  assign active  = position < POS_CW'(MAX_LEN);
  assign p       = POS_W'(position);
  assign p_plus1 = position + POS_CW'(1);

  assign mf_ext   = CMP_W'(max_flips);
  assign limit    = (mf_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : mf_ext;
  assign no_flips = limit == '0;
  assign is_zero  = active && !bit_value;
  assign pop      = is_zero && !no_flips && (CMP_W'(q_count) >= limit);

  always_comb begin
    if (is_zero && no_flips) begin
      wl_step = p_plus1;
    end else if (pop) begin
      wl_step = POS_CW'(q_head_val) + POS_CW'(1);
    end else begin
      wl_step = window_left;
    end
  end

  assign len = (p_plus1 >= wl_step) ? p_plus1 - wl_step : '0;

  // Strictly longer windows only, so the earliest best one is kept.
  always_comb begin
    res_len      = best_len;
    res_from     = best_from;
    res_to       = best_to;
    res_overflow = overflow_seen | !active;
    if (active && (len > best_len)) begin
      res_len  = len;
      res_from = wl_step;
      res_to   = p;
    end
  end

  assign q_cmd.push  = accept && is_zero && !no_flips;
  assign q_cmd.pop   = accept && pop;
  assign q_cmd.flush = accept && (last_bit || (is_zero && no_flips));
  assign q_push_pos  = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      window_left   <= '0;
      best_len      <= '0;
      best_from     <= '0;
      best_to       <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (last_bit) begin
        position      <= '0;
        window_left   <= '0;
        best_len      <= '0;
        best_from     <= '0;
        best_to       <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (active) begin
          position <= p_plus1;
        end
        window_left   <= active ? wl_step : window_left;
        best_len      <= res_len;
        best_from     <= res_from;
        best_to       <= res_to;
        overflow_seen <= res_overflow;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/longest_ones_run_with_k_flips_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Payload
// s_axis    in         tdata[0] bit_value, tlast last_bit
// m_axis    out        tdata best_length/best_start/best_end, tlast sequence_done,
//                      tuser too_long
// cfg       in         cfg_data max_flips
//
// One bit per cycle while m_axis is not stalled; a result appears in the cycle after its bit is accepted.
// The result register holds each result; the zero queue head is prefetched
// from a registered memory read, so a pop does not wait on the memory.
// rst is synchronous and active high; it clears max_flips and all sequence state.
// A stalled m_axis holds its result and s_axis accepts only when the result
// register is empty or being emptied in the same cycle.

module longest_ones_run_with_k_flips_unit #(
  parameter int unsigned MAX_LEN        = lokf_pkg::MAX_LEN_DEFAULT,
  parameter int unsigned MAX_FLIP_DEPTH = lokf_pkg::MAX_FLIP_DEPTH_DEFAULT
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire [lokf_pkg::IN_TDATA_W-1:0]        s_axis_tdata,   // [0] bit_value
  input  wire                                   s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // [16:0] best_length, [32:17] best_start, [48:33] best_end
  output logic [lokf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic                                  m_axis_tlast,
  output logic                                  m_axis_tuser,   // [0] too_long
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [lokf_pkg::MAX_FLIPS_W-1:0]       cfg_data
);

  localparam int unsigned POS_W  = $clog2(MAX_LEN);
  localparam int unsigned POS_CW = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W  = (MAX_FLIP_DEPTH > 1) ? $clog2(MAX_FLIP_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_FLIP_DEPTH + 1);
  localparam int unsigned PAD_W  = lokf_pkg::OUT_TDATA_W - lokf_pkg::BEST_LENGTH_W
                                   - 2 * lokf_pkg::BEST_POS_W;

  logic [lokf_pkg::MAX_FLIPS_W-1:0] max_flips;
  logic                             accept;
  lokf_pkg::q_cmd_t                 q_cmd;
  logic [POS_W-1:0]                 q_push_pos;
  logic [CNT_W-1:0]                 q_count;
  logic [POS_W-1:0]                 q_head_val;
  logic [POS_CW-1:0]                res_len;
  logic [POS_CW-1:0]                res_from;
  logic [POS_W-1:0]                 res_to;
  logic                             res_overflow;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_flips <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_flips <= cfg_data;
    end
  end

  lokf_window #(
    .MAX_LEN (MAX_LEN),
    .DEPTH   (MAX_FLIP_DEPTH),
    .POS_W   (POS_W),
    .POS_CW  (POS_CW),
    .CNT_W   (CNT_W)
  ) u_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .bit_value    (s_axis_tdata[0]),
    .last_bit     (s_axis_tlast),
    .max_flips    (max_flips),
    .q_count      (q_count),
    .q_head_val   (q_head_val),
    .q_cmd        (q_cmd),
    .q_push_pos   (q_push_pos),
    .res_len      (res_len),
    .res_from     (res_from),
    .res_to       (res_to),
    .res_overflow (res_overflow)
  );

  lokf_zero_queue #(
    .DEPTH (MAX_FLIP_DEPTH),
    .POS_W (POS_W),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_zero_queue (
    .clk      (clk),
    .rst      (rst),
    .cmd      (q_cmd),
    .push_pos (q_push_pos),
    .count    (q_count),
    .head_val (q_head_val)
  );

  // Result register: load on each transfer in, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {{PAD_W{1'b0}},
                       lokf_pkg::BEST_POS_W'(res_to),
                       lokf_pkg::BEST_POS_W'(res_from),
                       lokf_pkg::BEST_LENGTH_W'(res_len)};
      m_axis_tlast <= s_axis_tlast;
      m_axis_tuser <= res_overflow;
    end
  end

endmodule

`default_nettype wire
